// ----- sv/twrc_pkg.sv -----
// Shared types, constants and helpers for the TCP window rewrite and checksum block.
package twrc_pkg;

    // Packet limits and field widths
    localparam int DEFAULT_MAX_PACKET = 65535;
    localparam int LEN_W              = 16;
    localparam int ADDR_W             = 3;
    localparam int PDATA_W            = 32;

    // Configuration register index (word address)
    localparam logic [ADDR_W-3:0] REG_TARGET_WINDOW = 1'b0;

    // IPv4 header byte positions
    localparam int IDX_IHL      = 0;
    localparam int IDX_TLEN_HI  = 2;
    localparam int IDX_TLEN_LO  = 3;
    localparam int IDX_PROTO    = 9;
    localparam int IDX_ADDR_LO  = 12;
    localparam int IDX_ADDR_END = 20;

    // TCP header byte positions, relative to the TCP header start
    localparam int REL_DOFF     = 12;
    localparam int REL_FLAGS    = 13;
    localparam int REL_WIN      = 14;
    localparam int REL_CSUM_END = 17;

    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam int         ACK_BIT_POS   = 4;
    localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
    localparam logic [6:0] WIN_FIELD_OFF = 7'd14;

    typedef enum logic [2:0] {
        V_NOT_TCP   = 3'd0,
        V_TOO_SHORT = 3'd1,
        V_DISABLED  = 3'd2,
        V_ACK_CLEAR = 3'd3,
        V_MODIFIED  = 3'd4
    } t_verdict;

    // Per-packet state captured at the last byte
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [3:0]       ihl;
        logic [7:0]       proto;
        logic [15:0]      total_len;
        logic [3:0]       doff;
        logic             ack;
        logic [15:0]      acc;
        logic [7:0]       pend;
    } t_snap;

    // 16-bit ones' complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ----- sv/twrc_byte_track.sv -----
// Per-byte header parse and running checksum, with a snapshot at the last byte.
module twrc_byte_track
    import twrc_pkg::*;
#(
    parameter int MAX_PACKET = DEFAULT_MAX_PACKET
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_snap      o_snap
);

    localparam int IDX_W = $clog2(MAX_PACKET + 1);

    logic [IDX_W-1:0] r_index, n_index;
    logic [3:0]       r_ihl, n_ihl;
    logic [7:0]       r_proto, n_proto;
    logic [15:0]      r_total_len, n_total_len;
    logic [3:0]       r_doff, n_doff;
    logic             r_ack, n_ack;
    logic [15:0]      r_acc, n_acc;
    logic [7:0]       r_pend, n_pend;
    t_snap            r_snap;

    logic [5:0]       hdr;
    logic             in_range;
    logic             tcp_zone;
    logic [IDX_W-1:0] rel;
    logic [7:0]       c;

    always_comb begin
        hdr      = {r_ihl, 2'b00};
        in_range = r_index < IDX_W'(MAX_PACKET);
        tcp_zone = (r_ihl >= MIN_HDR_WORDS) && (r_index >= IDX_W'(hdr));
        rel      = r_index - IDX_W'(hdr);

        // Byte as it enters the sum: addresses, TCP header minus window/check, payload
        c = 8'd0;
        if (r_index >= IDX_W'(IDX_ADDR_LO) && r_index < IDX_W'(IDX_ADDR_END)) begin
            c = i_byte;
        end
        if (tcp_zone && (rel < IDX_W'(REL_WIN) || rel > IDX_W'(REL_CSUM_END))) begin
            c = i_byte;
        end
    end

    always_comb begin
        n_index     = r_index;
        n_ihl       = r_ihl;
        n_proto     = r_proto;
        n_total_len = r_total_len;
        n_doff      = r_doff;
        n_ack       = r_ack;
        n_acc       = r_acc;
        n_pend      = r_pend;
        if (i_take && in_range) begin
            n_index = r_index + IDX_W'(1);
            if (r_index == IDX_W'(IDX_IHL))     n_ihl = i_byte[3:0];
            if (r_index == IDX_W'(IDX_TLEN_HI)) n_total_len[15:8] = i_byte;
            if (r_index == IDX_W'(IDX_TLEN_LO)) n_total_len[7:0] = i_byte;
            if (r_index == IDX_W'(IDX_PROTO))   n_proto = i_byte;
            if (tcp_zone && rel == IDX_W'(REL_DOFF))  n_doff = i_byte[7:4];
            if (tcp_zone && rel == IDX_W'(REL_FLAGS)) n_ack = i_byte[ACK_BIT_POS];
            if (r_index[0]) begin
                n_acc = ones_add(r_acc, {r_pend, c});
            end else begin
                n_pend = c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_index     <= '0;
            r_ihl       <= '0;
            r_proto     <= '0;
            r_total_len <= '0;
            r_doff      <= '0;
            r_ack       <= 1'b0;
            r_acc       <= '0;
            r_pend      <= '0;
        end else begin
            r_index     <= n_index;
            r_ihl       <= n_ihl;
            r_proto     <= n_proto;
            r_total_len <= n_total_len;
            r_doff      <= n_doff;
            r_ack       <= n_ack;
            r_acc       <= n_acc;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_last) begin
            r_snap.len       <= LEN_W'(n_index);
            r_snap.ihl       <= n_ihl;
            r_snap.proto     <= n_proto;
            r_snap.total_len <= n_total_len;
            r_snap.doff      <= n_doff;
            r_snap.ack       <= n_ack;
            r_snap.acc       <= n_acc;
            r_snap.pend      <= n_pend;
        end
    end

    assign o_snap = r_snap;

endmodule

// ----- sv/twrc_result.sv -----
// Verdict, checksum fold and the output register.
module twrc_result
    import twrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic        i_out_ready,
    input  t_snap       i_snap,
    input  logic [15:0] i_target_window,
    output logic        o_valid,
    output t_verdict    o_verdict,
    output logic [15:0] o_new_window,
    output logic [15:0] o_new_checksum,
    output logic [6:0]  o_window_offset
);

    logic        r_valid;
    t_verdict    r_verdict, n_verdict;
    logic [15:0] r_window, n_window;
    logic [15:0] r_csum, n_csum;
    logic [6:0]  r_offset, n_offset;

    logic [5:0]  hdr;
    logic [3:0]  doff_eff;
    logic [6:0]  need_len;
    logic [15:0] pseudo_len;
    logic [15:0] odd_word;
    logic [18:0] wide_sum;
    logic [16:0] fold1;
    logic [15:0] fold2;

    always_comb begin
        hdr        = {i_snap.ihl, 2'b00};
        doff_eff   = (i_snap.doff < MIN_HDR_WORDS) ? MIN_HDR_WORDS : i_snap.doff;
        need_len   = 7'(hdr) + {1'b0, doff_eff, 2'b00};
        pseudo_len = i_snap.total_len - 16'(hdr);
        odd_word   = i_snap.len[0] ? {i_snap.pend, 8'h00} : 16'd0;

        // Five-term ones' complement sum, folded twice
        wide_sum = 19'(i_snap.acc) + 19'(odd_word) + 19'(PROTO_TCP)
                 + 19'(pseudo_len) + 19'(i_target_window);
        fold1    = 17'(wide_sum[15:0]) + 17'(wide_sum[18:16]);
        fold2    = fold1[15:0] + 16'(fold1[16]);

        n_window = 16'd0;
        n_csum   = 16'd0;
        n_offset = 7'd0;
        priority if (i_snap.ihl < MIN_HDR_WORDS || i_snap.len < LEN_W'(hdr)) begin
            n_verdict = V_TOO_SHORT;
        end else if (i_snap.proto != PROTO_TCP) begin
            n_verdict = V_NOT_TCP;
        end else if (i_snap.len < LEN_W'(need_len)) begin
            n_verdict = V_TOO_SHORT;
        end else if (i_target_window == 16'd0) begin
            n_verdict = V_DISABLED;
        end else if (!i_snap.ack) begin
            n_verdict = V_ACK_CLEAR;
        end else begin
            n_verdict = V_MODIFIED;
            n_window  = i_target_window;
            n_csum    = ~fold2;
            n_offset  = 7'(hdr) + WIN_FIELD_OFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_verdict <= n_verdict;
            r_window  <= n_window;
            r_csum    <= n_csum;
            r_offset  <= n_offset;
        end
    end

    assign o_valid         = r_valid;
    assign o_verdict       = r_verdict;
    assign o_new_window    = r_window;
    assign o_new_checksum  = r_csum;
    assign o_window_offset = r_offset;

endmodule

// ----- sv/tcp_window_rewrite_checksum.sv -----
// Top level: TCP window rewrite with checksum recompute over a byte stream.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------------------
//  in       | input     | i_in_valid / o_in_ready   | i_packet_byte, i_last_byte
//  out      | output    | o_out_valid / i_out_ready | o_verdict, o_new_window,
//           |           |                           | o_new_checksum, o_window_offset
//  config   | input     | APB psel/penable/pwrite   | paddr, pwdata, prdata (target_window)
//
// One byte per cycle, sustained unless a last byte waits (see below). A byte goes input
// register -> parse/sum state; a last byte also lands in a snapshot register, and its
// result moves on to the output register once that register is empty or draining.
// Non-last bytes never wait on the output side; a last byte waits only when
// both the snapshot and output registers hold undelivered results.
// Synchronous active-low reset clears parse/sum state, valid flags and target_window, not data registers.
module tcp_window_rewrite_checksum
    import twrc_pkg::*;
#(
    parameter int MAX_PACKET = DEFAULT_MAX_PACKET
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte stream in
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_packet_byte,
    input  logic               i_last_byte,
    // verdict out
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_verdict,
    output logic [15:0]        o_new_window,
    output logic [15:0]        o_new_checksum,
    output logic [6:0]         o_window_offset,
    // APB config
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Config register
    logic [15:0] r_target_window;

    // Input register
    logic        r_s1_valid;
    logic        r_s1_last;
    logic [7:0]  r_s1_byte;

    // Snapshot occupancy
    logic        r_snap_valid, n_snap_valid;

    logic        out_free;
    logic        snap_move;
    logic        snap_free;
    logic        s1_move;
    logic        in_take;
    logic        out_valid;
    t_snap       snap;
    t_verdict    verdict;

    // ---------------- APB ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_window <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[ADDR_W-1:2] == REG_TARGET_WINDOW) begin
            r_target_window <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_TARGET_WINDOW) begin
            prdata = PDATA_W'(r_target_window);
        end
    end

    // ---------------- flow control ----------------
    // Output register drains or is empty -> snapshot may move.
    // Only a last byte needs the snapshot slot; plain bytes always advance.
    assign out_free   = !out_valid || i_out_ready;
    assign snap_move  = r_snap_valid && out_free;
    assign snap_free  = !r_snap_valid || out_free;
    assign s1_move    = r_s1_valid && (!r_s1_last || snap_free);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_packet_byte;
            r_s1_last <= i_last_byte;
        end
    end

    assign n_snap_valid = (r_snap_valid && !snap_move) || (s1_move && r_s1_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else begin
            r_snap_valid <= n_snap_valid;
        end
    end

    // ---------------- datapath ----------------
    twrc_byte_track #(
        .MAX_PACKET (MAX_PACKET)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (s1_move),
        .i_byte  (r_s1_byte),
        .i_last  (r_s1_last),
        .o_snap  (snap)
    );

    twrc_result u_result (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (snap_move),
        .i_out_ready     (i_out_ready),
        .i_snap          (snap),
        .i_target_window (r_target_window),
        .o_valid         (out_valid),
        .o_verdict       (verdict),
        .o_new_window    (o_new_window),
        .o_new_checksum  (o_new_checksum),
        .o_window_offset (o_window_offset)
    );

    assign o_out_valid = out_valid;
    assign o_verdict   = verdict;

    // ---------------- checks ----------------
    // A last byte never leaves the input register into a snapshot that is occupied and not draining
    a_snap_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_last) |-> snap_free)
        else $error("snapshot overwritten by a new last byte");

    // Snapshot only loads from a last byte
    a_snap_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_snap_valid || snap_move) && !(s1_move && r_s1_last) |=> !r_snap_valid)
        else $error("snapshot valid without a last byte");

    // Unmodified verdicts carry zero patch fields
    a_zero_unless_modified: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && verdict != V_MODIFIED) |->
            (o_new_window == 16'd0 && o_new_checksum == 16'd0 && o_window_offset == 7'd0))
        else $error("patch fields set on an unmodified verdict");

    // Modified verdict: nonzero window, offset in 34..74 (IPv4 header length plus 14)
    a_modified_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && verdict == V_MODIFIED) |->
            (o_new_window != 16'd0 && o_window_offset >= 7'd34 && o_window_offset <= 7'd74))
        else $error("modified verdict with bad window or offset");

endmodule
